### hw/rtl/vbdd_pkg.sv
// vbdd_pkg: shared types and constants of the vertical byte delta decoder
// used by the parser, queue, output stage and top, depends on nothing
`default_nettype none

package vbdd_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 1024;
   localparam int MAX_PLANES  = 8;

   localparam logic [7:0] LIT_FLAG  = 8'h80;
   localparam logic [7:0] LIT_MASK  = 8'h7F;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_ROWS    = 2'd1;
   localparam logic [1:0] CSR_XOR     = 2'd2;

   typedef struct packed {
      logic [8:0]  columns_in_use;
      logic [10:0] rows_in_use;
      logic        xor_mode;
   } cfg_type;

   typedef struct packed {
      logic [2:0] out_plane;
      logic [7:0] out_column;
      logic [9:0] start_row;
      logic [7:0] write_data;
      logic [7:0] row_count;
      logic       combine_xor;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

`default_nettype wire

### hw/rtl/vbdd_front.sv
// vbdd_front: op stream parser, one byte per cycle while take is high, issues write commands
// depends on vbdd_pkg
`default_nettype none

module vbdd_front
   import vbdd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       take,
   input  wire logic [7:0] op_byte,
   input  wire logic [2:0] plane_index,
   input  wire logic       first_of_plane,
   output cmd_type         cmd,
   output logic            cmd_push
);

   localparam logic [2:0] PH_COUNT     = 3'd0;
   localparam logic [2:0] PH_OP        = 3'd1;
   localparam logic [2:0] PH_LITERAL   = 3'd2;
   localparam logic [2:0] PH_RUN_COUNT = 3'd3;
   localparam logic [2:0] PH_RUN_FILL  = 3'd4;
   localparam logic [2:0] PH_DONE      = 3'd5;

   localparam logic [10:0] ROW_LIMIT = 11'(MAX_ROWS);
   localparam logic [8:0]  COL_LIMIT = 9'(MAX_COLUMNS);

   logic [2:0]  phase_ff, phase_in;
   logic [8:0]  col_ff, col_in;
   logic [10:0] row_ff, row_in;
   logic [7:0]  ops_ff, ops_in;
   logic [7:0]  bytes_ff, bytes_in;
   logic [7:0]  run_ff, run_in;
   logic [2:0]  plane_ff, plane_in;

   logic [10:0] eff_rows;
   logic [8:0]  eff_cols;
   logic [2:0]  ph;
   logic [8:0]  col_cur;
   logic [10:0] row_cur;
   logic [7:0]  ops_cur;
   logic [7:0]  bytes_cur;
   logic [7:0]  run_cur;
   logic [7:0]  emit_req;
   logic [10:0] room;
   logic        emit_hit;
   logic [7:0]  emit_cnt;
   logic [11:0] skip_sum;
   logic [8:0]  col_next;
   logic [2:0]  ph_next_col;
   logic        emit_now;

   assign eff_rows = (cfg.rows_in_use > ROW_LIMIT) ? ROW_LIMIT : cfg.rows_in_use;
   assign eff_cols = (cfg.columns_in_use > COL_LIMIT) ? COL_LIMIT : cfg.columns_in_use;

   always_comb begin
      ph        = phase_ff;
      col_cur   = col_ff;
      row_cur   = row_ff;
      ops_cur   = ops_ff;
      bytes_cur = bytes_ff;
      run_cur   = run_ff;
      plane_in  = plane_ff;
      if (first_of_plane) begin
         plane_in  = plane_index;
         col_cur   = '0;
         row_cur   = '0;
         ops_cur   = '0;
         bytes_cur = '0;
         run_cur   = '0;
         ph        = PH_COUNT;
      end
      if (ph == PH_COUNT && col_cur >= eff_cols) begin
         ph = PH_DONE;
      end
   end

   // shared write clipping, skip sum and next-column phase
   always_comb begin
      emit_req = (ph == PH_LITERAL) ? 8'd1 : run_cur;
      room     = eff_rows - row_cur;
      emit_hit = (row_cur < eff_rows) && (emit_req != 8'd0);
      emit_cnt = ({3'b000, emit_req} > room) ? room[7:0] : emit_req;
      skip_sum = {1'b0, row_cur} + {4'b0000, op_byte};
      col_next = col_cur + 9'd1;
      ph_next_col = (col_next >= eff_cols) ? PH_DONE : PH_COUNT;
   end

   always_comb begin
      phase_in = ph;
      col_in   = col_cur;
      row_in   = row_cur;
      ops_in   = ops_cur;
      bytes_in = bytes_cur;
      run_in   = run_cur;
      emit_now = 1'b0;
      unique case (ph)
         PH_COUNT: begin
            ops_in = op_byte;
            row_in = '0;
            if (op_byte == 8'd0) begin
               col_in   = col_next;
               phase_in = ph_next_col;
            end else begin
               phase_in = PH_OP;
            end
         end
         PH_OP: begin
            ops_in = ops_cur - 8'd1;
            if ((op_byte & LIT_FLAG) != 8'd0) begin
               bytes_in = op_byte & LIT_MASK;
               if (bytes_in != 8'd0) begin
                  phase_in = PH_LITERAL;
               end else if (ops_in == 8'd0) begin
                  col_in   = col_next;
                  row_in   = '0;
                  phase_in = ph_next_col;
               end else begin
                  phase_in = PH_OP;
               end
            end else if (op_byte == 8'd0) begin
               phase_in = PH_RUN_COUNT;
            end else begin
               row_in = (skip_sum > {1'b0, eff_rows}) ? eff_rows : skip_sum[10:0];
               if (ops_in == 8'd0) begin
                  col_in   = col_next;
                  row_in   = '0;
                  phase_in = ph_next_col;
               end else begin
                  phase_in = PH_OP;
               end
            end
         end
         PH_LITERAL: begin
            emit_now = emit_hit;
            if (emit_hit) begin
               row_in = row_cur + {3'b000, emit_cnt};
            end
            bytes_in = (bytes_cur - 8'd1) & BYTE_MASK;
            if (bytes_in == 8'd0) begin
               if (ops_in == 8'd0) begin
                  col_in   = col_next;
                  row_in   = '0;
                  phase_in = ph_next_col;
               end else begin
                  phase_in = PH_OP;
               end
            end
         end
         PH_RUN_COUNT: begin
            run_in   = op_byte;
            phase_in = PH_RUN_FILL;
         end
         PH_RUN_FILL: begin
            emit_now = emit_hit;
            if (emit_hit) begin
               row_in = row_cur + {3'b000, emit_cnt};
            end
            if (ops_in == 8'd0) begin
               col_in   = col_next;
               row_in   = '0;
               phase_in = ph_next_col;
            end else begin
               phase_in = PH_OP;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_comb begin
      cmd.out_plane   = plane_in;
      cmd.out_column  = col_cur[7:0];
      cmd.start_row   = row_cur[9:0];
      cmd.write_data  = op_byte;
      cmd.row_count   = emit_cnt;
      cmd.combine_xor = cfg.xor_mode;
      cmd_push        = take && emit_now && (32'(plane_in) < MAX_PLANES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         col_ff   <= '0;
         row_ff   <= '0;
         ops_ff   <= '0;
         bytes_ff <= '0;
         run_ff   <= '0;
         plane_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ops_ff   <= ops_in;
         bytes_ff <= bytes_in;
         run_ff   <= run_in;
         plane_ff <= plane_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vbdd_queue.sv
// vbdd_queue: short command queue between parser and output stage
// depends on vbdd_pkg
`default_nettype none

module vbdd_queue
   import vbdd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output qstat_type    stat
);

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in;
   logic [QPTR_W-1:0]       rd_ff, rd_in;
   logic [QPTR_W:0]         cnt_ff, cnt_in;
   logic                    do_push;
   logic                    do_pop;

   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_cmd   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vbdd_back.sv
// vbdd_back: output register that drains the command queue onto the response side
// depends on vbdd_pkg
`default_nettype none

module vbdd_back
   import vbdd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire qstat_type stat,
   input  wire cmd_type   head_cmd,
   output logic           pop,
   input  wire logic      rsp_tready,
   output logic           rsp_tvalid,
   output cmd_type        rsp_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff;

   assign pop        = !stat.empty && (!valid_ff || rsp_tready);
   assign valid_in   = pop || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_cmd    = cmd_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vertical_byte_delta_decoder_top.sv
// vertical_byte_delta_decoder_top: config registers, parser, queue and output stage
// depends on vbdd_pkg, vbdd_front, vbdd_queue, vbdd_back
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tdata: op_byte, plane_index; tuser: first_of_plane
// rsp      out  rsp_tvalid/rsp_tready   tdata: plane, column, start row, data, count
//                                       tuser: combine_xor
// csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// one request per cycle unless req stalls; commands reach rsp via queue and output register
// rate is set by the parser's registered state update, one byte per clock unless stalled
// a four-entry queue plus the output register absorb rsp stalls; req stalls when full
// synchronous reset clears parser state, queue pointers and rsp_tvalid
// csr is always ready and writes are registered into the config on the clock they are taken
`default_nettype none

module vertical_byte_delta_decoder_top
   import vbdd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // op_byte[7:0], plane_index[10:8], bits 15:11 unused
   input  wire logic [0:0]  req_tuser,   // first_of_plane
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // out_plane[2:0], out_column[10:3],
                                         // start_row[20:11], write_data[28:21],
                                         // row_count[36:29], zero pad
   output logic [0:0]       rsp_tuser,   // combine_xor
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);

   cfg_type   cfg_ff;
   cmd_type   front_cmd;
   cmd_type   head_cmd;
   cmd_type   rsp_cmd;
   qstat_type stat;
   logic      push;
   logic      pop;
   logic      take;

   assign csr_ready  = 1'b1;
   assign req_tready = !stat.full;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns_in_use <= 9'd40;
         cfg_ff.rows_in_use    <= 11'd200;
         cfg_ff.xor_mode       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMNS: cfg_ff.columns_in_use <= csr_data[8:0];
            CSR_ROWS:    cfg_ff.rows_in_use    <= csr_data;
            CSR_XOR:     cfg_ff.xor_mode       <= csr_data[0];
            default: ;
         endcase
      end
   end

   vbdd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .take           (take),
      .op_byte        (req_tdata[7:0]),
      .plane_index    (req_tdata[10:8]),
      .first_of_plane (req_tuser[0]),
      .cmd            (front_cmd),
      .cmd_push       (push)
   );

   vbdd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   vbdd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_cmd    (rsp_cmd)
   );

   assign rsp_tdata = {3'b000, rsp_cmd.row_count, rsp_cmd.write_data,
                       rsp_cmd.start_row, rsp_cmd.out_column, rsp_cmd.out_plane};
   assign rsp_tuser = rsp_cmd.combine_xor;

endmodule

`default_nettype wire

### hw/rtl/vbdd_checker.sv
// vbdd_checker: port-level assertions for the decoder top, attached by bind
// depends on vertical_byte_delta_decoder_top ports only
`default_nettype none

module vbdd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        csr_ready
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // a write command always covers at least one row
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:29] != 8'd0)
      else $error("zero row count");

   // pad bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:37] == 3'b000)
      else $error("rsp pad bits set");

   // reset empties the output side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_ready)
      else $error("rsp valid after reset");

endmodule

bind vertical_byte_delta_decoder_top vbdd_checker u_vbdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);

`default_nettype wire
